/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl in this folder
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lrtpd_pkg.sv */
// types, constants and helper functions for the led ring tilt pwm driver
// no dependencies
package lrtpd_pkg;

    localparam int LED_COUNT = 8;
    localparam int LED_IDX_W = $clog2(LED_COUNT);
    localparam int ON_W      = 10;

    localparam int MODE_W      = 2;
    localparam int TILT_W      = 16;
    localparam int IN_FIELDS_W = MODE_W + LED_IDX_W + TILT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    typedef logic [ON_W-1:0]      on_t;
    typedef logic [LED_COUNT-1:0] led_mask_t;
    typedef logic [LED_IDX_W-1:0] led_idx_t;
    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [TILT_W-1:0]    tilt_t;
    typedef logic [1:0]           band_t;

    localparam mode_t MODE_LEVEL = 2'd0;
    localparam mode_t MODE_CALIB = 2'd1;
    localparam mode_t MODE_FLAT  = 2'd2;

    localparam band_t BAND_LOW  = 2'd0;
    localparam band_t BAND_MID  = 2'd1;
    localparam band_t BAND_HIGH = 2'd2;

    localparam tilt_t TILT_MID_TH  = 16'd4000;
    localparam tilt_t TILT_HIGH_TH = 16'd6000;

    localparam on_t PERIOD_RELOAD = 10'd1000;
    localparam on_t TICK_STEP     = 10'd10;

    localparam led_mask_t PATTERN_ALL  = 8'hFF;
    localparam led_mask_t PATTERN_NONE = 8'h00;

    function automatic band_t tilt_band(input tilt_t tilt);
        band_t b;
        if (tilt < TILT_MID_TH)
            b = BAND_LOW;
        else if (tilt < TILT_HIGH_TH)
            b = BAND_MID;
        else
            b = BAND_HIGH;
        return b;
    endfunction

    // on-time for an led at the given ring distance from the centre
    function automatic on_t ring_level(input led_idx_t ofs, input band_t band);
        on_t lvl_max;
        on_t lvl_adj;
        on_t lvl_out;
        on_t lvl;
        case (band)
            BAND_LOW:
            begin
                lvl_max = 10'd200;  lvl_adj = 10'd20;  lvl_out = 10'd10;
            end
            BAND_MID:
            begin
                lvl_max = 10'd600;  lvl_adj = 10'd60;  lvl_out = 10'd20;
            end
            default:
            begin
                lvl_max = 10'd1000; lvl_adj = 10'd200; lvl_out = 10'd50;
            end
        endcase
        case (ofs)
            3'd0:       lvl = lvl_max;
            3'd1, 3'd7: lvl = lvl_adj;
            3'd2, 3'd6: lvl = lvl_out;
            default:    lvl = '0;
        endcase
        return lvl;
    endfunction

    function automatic logic ring_lit(input led_idx_t ofs);
        logic lit;
        case (ofs)
            3'd0, 3'd1, 3'd2, 3'd6, 3'd7: lit = 1'b1;
            default:                      lit = 1'b0;
        endcase
        return lit;
    endfunction

    function automatic on_t sat_step(input on_t v);
        return (v > TICK_STEP) ? on_t'(v - TICK_STEP) : '0;
    endfunction

    // fixed patterns for NW, W, SW, S, SE, E, NE, N
    function automatic led_mask_t calib_pattern(input led_idx_t dir);
        led_mask_t p;
        case (dir)
            3'd0:    p = 8'hAA;
            3'd1:    p = 8'h02;
            3'd2:    p = 8'h55;
            3'd3:    p = 8'h08;
            3'd4:    p = 8'h10;
            3'd5:    p = 8'h20;
            3'd6:    p = 8'h40;
            default: p = 8'h80;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/led_ring_tilt_pwm_driver_unit.sv */
// led ring tilt pwm driver: one refresh tick per input beat, 8-bit led pattern out
// depends on lrtpd_pkg and assert_macros.svh
//
// an accepted input beat passes through the input register, then the result register
// after one pass of tick logic, which in level mode updates all eight counters at once
// throughput: one beat per cycle while the output is not stalled
// reset: clears the valid flags, the on-time counters, the period counter and the lit mask
module led_ring_tilt_pwm_driver_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] mode, [4:2] center, [20:5] tilt, [23:21] zero
    input  logic [lrtpd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] led_pattern
    output logic [lrtpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lrtpd_pkg::*;

    logic      in_valid_reg;
    mode_t     in_mode_reg;
    led_idx_t  in_center_reg;
    tilt_t     in_tilt_reg;

    logic      out_valid_reg;
    led_mask_t out_pattern_reg;

    on_t       on_time_reg [LED_COUNT];
    on_t       on_time_next [LED_COUNT];
    on_t       on_eff [LED_COUNT];
    on_t       period_reg;
    on_t       period_next;
    led_mask_t lit_mask_reg;
    led_mask_t lit_mask_next;
    led_mask_t pattern;

    logic      out_free;
    logic      step;
    logic      reload;
    band_t     band;
    led_idx_t  ring_ofs [LED_COUNT];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pattern_reg;

    assign reload = (period_reg == '0);
    assign band   = tilt_band(in_tilt_reg);

    always_comb
    begin
        for (int k = 0; k < LED_COUNT; k++)
        begin
            ring_ofs[k] = led_idx_t'(k) - in_center_reg;
            on_eff[k]   = reload ? ring_level(ring_ofs[k], band) : on_time_reg[k];
        end
    end

    always_comb
    begin
        on_time_next  = on_time_reg;
        period_next   = period_reg;
        lit_mask_next = lit_mask_reg;
        pattern       = PATTERN_NONE;
        case (in_mode_reg)
            MODE_LEVEL:
            begin
                // reload comes first, then the per-led spend check
                period_next = sat_step(reload ? PERIOD_RELOAD : period_reg);
                for (int k = 0; k < LED_COUNT; k++)
                begin
                    lit_mask_next[k] = (reload ? ring_lit(ring_ofs[k]) : lit_mask_reg[k])
                                       && (on_eff[k] != '0);
                    on_time_next[k]  = sat_step(on_eff[k]);
                end
                pattern = lit_mask_next;
            end
            MODE_CALIB:
                pattern = calib_pattern(in_center_reg);
            MODE_FLAT:
                pattern = PATTERN_ALL;
            default:
                pattern = PATTERN_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= '0;
            lit_mask_reg  <= '0;
            for (int k = 0; k < LED_COUNT; k++)
                on_time_reg[k] <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                period_reg   <= period_next;
                lit_mask_reg <= lit_mask_next;
                on_time_reg  <= on_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg   <= s_axis_tdata[MODE_W-1:0];
            in_center_reg <= s_axis_tdata[MODE_W +: LED_IDX_W];
            in_tilt_reg   <= s_axis_tdata[MODE_W+LED_IDX_W +: TILT_W];
        end
        if (step)
            out_pattern_reg <= pattern;
    end

    `include "assert_macros.svh"

    `ASSERT_SAME(a_period_range, clk, rst_n, 1'b1, period_reg <= PERIOD_RELOAD, "period out of range")
    `ASSERT_SAME(a_lit_count, clk, rst_n, 1'b1, $countones(lit_mask_reg) <= 5, "too many leds lit")
    `ASSERT_NEXT(a_step_fills_out, clk, rst_n, step, out_valid_reg, "beat lost after tick")
    `ASSERT_NEXT(a_non_level_keeps, clk, rst_n, step && in_mode_reg != MODE_LEVEL, $stable(period_reg) && $stable(lit_mask_reg), "state changed outside level mode")

endmodule

/* tb/sv/led_ring_pattern_monitor.sv */
// watches both stream ports of the led ring driver, predicts each led pattern and compares
// depends on lrtpd_pkg for field types and the band thresholds
module led_ring_pattern_monitor
    import lrtpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                     errors,
    output int                     pending
);

    localparam mode_t MODE_BLANK = 2'd3;

    localparam logic [11:0] LOW_CENTER  = 12'd200;
    localparam logic [11:0] LOW_ADJ     = 12'd20;
    localparam logic [11:0] LOW_OUTER   = 12'd10;
    localparam logic [11:0] MID_CENTER  = 12'd600;
    localparam logic [11:0] MID_ADJ     = 12'd60;
    localparam logic [11:0] MID_OUTER   = 12'd20;
    localparam logic [11:0] HIGH_CENTER = 12'd1000;
    localparam logic [11:0] HIGH_ADJ    = 12'd200;
    localparam logic [11:0] HIGH_OUTER  = 12'd50;
    localparam logic [10:0] PERIOD_FULL = 11'd1000;
    localparam logic [11:0] STEP        = 12'd10;
    localparam logic [10:0] PERIOD_STEP = 11'd10;

    // NW, W, SW, S, SE, E, NE, N
    localparam led_mask_t CALIB_PATTERNS [8] = '{
        8'hAA, 8'h02, 8'h55, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    logic [11:0] led_on_time [LED_COUNT];
    logic [10:0] period_left;
    led_mask_t   lit_leds;
    led_mask_t   expected_patterns [$];
    led_mask_t   next_pattern;
    led_mask_t   oldest_pattern;
    int          mismatch_count;

    task automatic reset_ring();
        int k;
        for (k = 0; k < LED_COUNT; k++)
            led_on_time[k] = '0;
        period_left = '0;
        lit_leds    = '0;
    endtask

    // one refresh tick of the ring, returns the pattern shown on this tick
    task automatic advance_ring(input mode_t mode, input led_idx_t center, input tilt_t tilt,
                                output led_mask_t pattern);
        logic [11:0] lvl_center;
        logic [11:0] lvl_adj;
        logic [11:0] lvl_outer;
        led_idx_t    right1;
        led_idx_t    right2;
        led_idx_t    left1;
        led_idx_t    left2;
        int          k;
        pattern = PATTERN_NONE;
        case (mode)
            MODE_LEVEL:
            begin
                if (period_left == '0)
                begin
                    if (tilt < TILT_MID_TH)
                    begin
                        lvl_center = LOW_CENTER;  lvl_adj = LOW_ADJ;  lvl_outer = LOW_OUTER;
                    end
                    else if (tilt < TILT_HIGH_TH)
                    begin
                        lvl_center = MID_CENTER;  lvl_adj = MID_ADJ;  lvl_outer = MID_OUTER;
                    end
                    else
                    begin
                        lvl_center = HIGH_CENTER; lvl_adj = HIGH_ADJ; lvl_outer = HIGH_OUTER;
                    end
                    // ring neighbors wrap around through the 3-bit index
                    right1 = center + 3'd1;
                    right2 = center + 3'd2;
                    left1  = center - 3'd1;
                    left2  = center - 3'd2;
                    for (k = 0; k < LED_COUNT; k++)
                        led_on_time[k] = '0;
                    led_on_time[center] = lvl_center;
                    led_on_time[right1] = lvl_adj;
                    led_on_time[left1]  = lvl_adj;
                    led_on_time[right2] = lvl_outer;
                    led_on_time[left2]  = lvl_outer;
                    lit_leds = '0;
                    lit_leds[center] = 1'b1;
                    lit_leds[right1] = 1'b1;
                    lit_leds[left1]  = 1'b1;
                    lit_leds[right2] = 1'b1;
                    lit_leds[left2]  = 1'b1;
                    period_left = PERIOD_FULL;
                end
                for (k = 0; k < LED_COUNT; k++)
                begin
                    if (led_on_time[k] == '0)
                        lit_leds[k] = 1'b0;
                    led_on_time[k] = (led_on_time[k] > STEP) ? led_on_time[k] - STEP : '0;
                end
                period_left = (period_left > PERIOD_STEP) ? period_left - PERIOD_STEP : '0;
                pattern = lit_leds;
            end
            MODE_CALIB: pattern = CALIB_PATTERNS[center];
            MODE_FLAT:  pattern = PATTERN_ALL;
            MODE_BLANK: pattern = PATTERN_NONE;
            default:    pattern = PATTERN_NONE;
        endcase
    endtask

    initial
    begin
        reset_ring();
        mismatch_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_ring();
            expected_patterns.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_patterns.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output beat: led_pattern %02h", m_axis_tdata);
                end
                else
                begin
                    oldest_pattern = expected_patterns.pop_front();
                    if (m_axis_tdata !== oldest_pattern)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("led_pattern mismatch: expected %02h, got %02h",
                                     oldest_pattern, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_ring(mode_t'(s_axis_tdata[1:0]), led_idx_t'(s_axis_tdata[4:2]),
                             tilt_t'(s_axis_tdata[20:5]), next_pattern);
                expected_patterns.push_back(next_pattern);
            end
        end
        pending <= expected_patterns.size();
        errors  <= mismatch_count;
    end

endmodule

/* tb/sv/led_ring_tilt_pwm_driver_unit_tb.sv */
// top of the led ring driver testbench: clock, reset, stimulus phases and the verdict
// depends on lrtpd_pkg, led_ring_tilt_pwm_driver_unit and led_ring_pattern_monitor
module led_ring_tilt_pwm_driver_unit_tb;
    import lrtpd_pkg::*;

    localparam mode_t MODE_BLANK = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [1:0] mode, [4:2] center, [20:5] tilt, [23:21] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] led_pattern
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    always #5 clk = ~clk;

    led_ring_tilt_pwm_driver_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    led_ring_pattern_monitor pattern_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    function automatic logic [IN_TDATA_W-1:0] pack_tick(input mode_t mode, input led_idx_t center,
                                                        input tilt_t tilt);
        return {3'b000, tilt, center, mode};
    endfunction

    // mostly level ticks so the period keeps expiring, tilt leaning on the band edges
    function automatic logic [IN_TDATA_W-1:0] random_tick();
        int    roll;
        mode_t mode;
        tilt_t tilt;
        roll = $urandom_range(99);
        if (roll < 80)
            mode = MODE_LEVEL;
        else if (roll < 88)
            mode = MODE_CALIB;
        else if (roll < 94)
            mode = MODE_FLAT;
        else
            mode = MODE_BLANK;
        case ($urandom_range(9))
            0:       tilt = TILT_MID_TH - 16'd1;
            1:       tilt = TILT_MID_TH;
            2:       tilt = TILT_HIGH_TH - 16'd1;
            3:       tilt = TILT_HIGH_TH;
            4:       tilt = 16'($urandom_range(7999));
            default: tilt = 16'($urandom);
        endcase
        return pack_tick(mode, led_idx_t'($urandom_range(7)), tilt);
    endfunction

    task automatic send_tick(input logic [IN_TDATA_W-1:0] beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // pause the sender until every predicted pattern has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_tick(random_tick());
        wait_drained();
    endtask

    // receiver side: random stalls, plus a long counted hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int d;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first level tick reloads from the zero period, then field extremes
        send_tick(pack_tick(MODE_LEVEL, 3'd0, 16'd0));
        send_tick(pack_tick(MODE_LEVEL, 3'd7, 16'hFFFF));
        for (d = 0; d < 8; d++)
            send_tick(pack_tick(MODE_CALIB, led_idx_t'(d), 16'($urandom)));
        send_tick(pack_tick(MODE_FLAT, 3'd7, 16'hFFFF));
        send_tick(pack_tick(MODE_BLANK, 3'd7, 16'hFFFF));
        send_tick(pack_tick(MODE_BLANK, 3'd0, 16'd0));
        send_tick(pack_tick(MODE_LEVEL, 3'd3, TILT_MID_TH - 16'd1));
        send_tick(pack_tick(MODE_LEVEL, 3'd4, TILT_MID_TH));
        send_tick(pack_tick(MODE_LEVEL, 3'd5, TILT_HIGH_TH - 16'd1));
        send_tick(pack_tick(MODE_LEVEL, 3'd6, TILT_HIGH_TH));
        send_tick(pack_tick(MODE_FLAT, 3'd0, 16'd0));
        send_tick(pack_tick(MODE_CALIB, 3'd7, 16'hFFFF));
        wait_drained();

        run_phase(260, 0, 0);

        // hold the output off long enough that the block backs up into its input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 150;
        repeat (40)
            send_tick(random_tick());
        wait_drained();

        run_phase(260, 68, 0);
        run_phase(260, 0, 68);
        run_phase(260, 20, 20);

        repeat (5) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* led_ring_tilt_pwm_driver_unit.f */
+incdir+rtl/core
rtl/core/lrtpd_pkg.sv
rtl/core/led_ring_tilt_pwm_driver_unit.sv
tb/sv/led_ring_pattern_monitor.sv
tb/sv/led_ring_tilt_pwm_driver_unit_tb.sv
